[rtl/bca_pkg.sv]
`default_nettype none

package bca_pkg;

	localparam int NUM_BLOCKS = 4096;
	localparam int AW         = $clog2(NUM_BLOCKS);

	localparam logic [15:0] ENTRY_FREE = 16'h0000;
	localparam logic [15:0] ENTRY_END  = 16'hFFFF;

	localparam logic [AW-1:0] BLK_LAST = AW'(NUM_BLOCKS - 1);
	localparam logic [AW-1:0] BLK_ONE  = AW'(1);

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_LINK  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_ALLOC_SCAN,
		S_NEXT_SCAN,
		S_FREE_RD,
		S_FREE_CHK,
		S_RD_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic            re;
		logic [AW-1:0]   raddr;
		logic            we;
		logic [AW-1:0]   waddr;
		logic [15:0]     wdata;
	} mem_req_t;

	typedef struct packed {
		logic [15:0] result_block;
		logic [15:0] free_left;
		status_t     status;
	} result_t;

	function automatic logic in_range(input logic [15:0] x);
		return 17'(x) < 17'(NUM_BLOCKS);
	endfunction

	// step to the next block of the search, wrapping past the root
	function automatic logic [AW-1:0] blk_wrap(input logic [AW-1:0] a);
		return (a == BLK_LAST) ? BLK_ONE : a + BLK_ONE;
	endfunction

endpackage

`default_nettype wire

[rtl/bca_in_if.sv]
`default_nettype none

interface bca_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] block_index;
	logic [15:0] next_value;

	modport source (output valid, cmd, block_index, next_value, input ready);
	modport sink   (input valid, cmd, block_index, next_value, output ready);
endinterface

`default_nettype wire

[rtl/bca_out_if.sv]
`default_nettype none

interface bca_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_block;
	logic [15:0] free_left;
	logic [1:0]  status;

	modport source (output valid, result_block, free_left, status, input ready);
	modport sink   (input valid, result_block, free_left, status, output ready);
endinterface

`default_nettype wire

[rtl/bca_ram.sv]
`default_nettype none

module bca_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// same-cycle write to the read address is forwarded
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bca_ctrl.sv]
`default_nettype none

module bca_ctrl
	import bca_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  cmd,
	input  wire logic [15:0] block_index,
	input  wire logic [15:0] next_value,
	input  wire logic        out_free,
	output logic             done,
	output result_t          result,
	output mem_req_t         mreq,
	input  wire logic [15:0] rdata
);

	localparam logic [AW:0] STEP_LIM = (AW+1)'(NUM_BLOCKS);

	state_t          state_q, state_d;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   cnt_q;
	logic [AW-1:0]   ff_q;
	logic [AW-1:0]   scan_q;
	logic [AW-1:0]   issued_q;
	logic            pend_s1;
	logic [AW-1:0]   addr_s1;
	logic [15:0]     pos_q;
	logic [AW:0]     steps_q;
	logic [15:0]     res_q;
	status_t         stat_q;

	cmd_t            cmd_c;
	logic            acc;
	logic            idx_ok;
	logic            scanning;
	logic            hit;
	logic            miss_last;
	logic            issue;
	logic [AW:0]     steps_nx;
	logic            nx_ok;
	logic [AW-1:0]   ff_start;
	logic [AW-1:0]   pos_a;

	assign cmd_c     = cmd_t'(cmd);
	assign acc       = in_valid && in_ready;
	assign idx_ok    = in_range(block_index);
	assign scanning  = (state_q == S_ALLOC_SCAN) || (state_q == S_NEXT_SCAN);
	assign hit       = pend_s1 && (rdata == ENTRY_FREE);
	assign miss_last = pend_s1 && (rdata != ENTRY_FREE) && (issued_q == BLK_LAST);
	assign issue     = scanning && !hit && (issued_q != BLK_LAST);
	assign steps_nx  = steps_q + 1'b1;
	assign nx_ok     = (rdata != ENTRY_FREE) && in_range(rdata) && (steps_nx < STEP_LIM);
	assign ff_start  = ((ff_q == '0) || (32'(ff_q) >= NUM_BLOCKS)) ? BLK_ONE : ff_q;
	assign pos_a     = pos_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == BLK_LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc) begin
					case (cmd_c)
						CMD_ALLOC: state_d = S_ALLOC_SCAN;
						CMD_FREE: begin
							if (idx_ok && (block_index != 16'd0)) state_d = S_FREE_RD;
							else state_d = S_FINISH;
						end
						CMD_READ: state_d = idx_ok ? S_RD_WAIT : S_FINISH;
						default: state_d = S_FINISH;
					endcase
				end
			end
			S_ALLOC_SCAN: begin
				if (hit) state_d = S_NEXT_SCAN;
				else if (miss_last) state_d = S_FINISH;
			end
			S_NEXT_SCAN: begin
				if (hit || miss_last) state_d = S_FINISH;
			end
			S_FREE_RD: state_d = S_FREE_CHK;
			S_FREE_CHK: begin
				if (!nx_ok) state_d = S_FINISH;
			end
			S_RD_WAIT: state_d = S_FINISH;
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mreq     = '0;
		in_ready = 1'b0;
		done     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				mreq.we    = 1'b1;
				mreq.waddr = clr_q;
				mreq.wdata = (clr_q == '0) ? ENTRY_END : ENTRY_FREE;
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				mreq.raddr = block_index[AW-1:0];
				mreq.waddr = block_index[AW-1:0];
				mreq.wdata = next_value;
				mreq.we    = acc && (cmd_c == CMD_LINK) && idx_ok;
				mreq.re    = acc && (cmd_c == CMD_READ) && idx_ok;
			end
			S_ALLOC_SCAN, S_NEXT_SCAN: begin
				mreq.re    = issue;
				mreq.raddr = scan_q;
				mreq.we    = hit && (state_q == S_ALLOC_SCAN);
				mreq.waddr = addr_s1;
				mreq.wdata = ENTRY_END;
			end
			S_FREE_RD: begin
				mreq.re    = 1'b1;
				mreq.raddr = pos_a;
			end
			S_FREE_CHK: begin
				mreq.we    = (rdata != ENTRY_FREE);
				mreq.waddr = pos_a;
				mreq.wdata = ENTRY_FREE;
				mreq.re    = nx_ok;
				mreq.raddr = rdata[AW-1:0];
			end
			S_FINISH: done = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			cnt_q    <= BLK_LAST;
			ff_q     <= BLK_ONE;
			pend_s1  <= 1'b0;
			issued_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_CLEAR: clr_q <= clr_q + BLK_ONE;
				S_IDLE: begin
					if (acc) begin
						res_q    <= 16'd0;
						stat_q   <= ST_OK;
						if ((cmd_c != CMD_ALLOC) && !idx_ok) stat_q <= ST_RANGE;
						scan_q   <= ff_start;
						issued_q <= '0;
						pend_s1  <= 1'b0;
						pos_q    <= block_index;
						steps_q  <= '0;
					end
				end
				S_ALLOC_SCAN, S_NEXT_SCAN: begin
					pend_s1 <= issue;
					addr_s1 <= scan_q;
					if (issue) begin
						scan_q   <= blk_wrap(scan_q);
						issued_q <= issued_q + BLK_ONE;
					end
					if (state_q == S_ALLOC_SCAN) begin
						if (hit) begin
							res_q    <= 16'(addr_s1);
							if (cnt_q != '0) cnt_q <= cnt_q - BLK_ONE;
							scan_q   <= blk_wrap(addr_s1);
							issued_q <= '0;
						end else if (miss_last) begin
							stat_q <= ST_FULL;
						end
					end else begin
						if (hit) ff_q <= addr_s1;
						else if (miss_last) ff_q <= BLK_ONE;
					end
				end
				S_FREE_CHK: begin
					if (rdata != ENTRY_FREE) begin
						if (cnt_q != BLK_LAST) cnt_q <= cnt_q + BLK_ONE;
						if (pos_a < ff_q) ff_q <= pos_a;
						steps_q <= steps_nx;
						pos_q   <= rdata;
					end
				end
				S_RD_WAIT: res_q <= rdata;
				default: ;
			endcase
		end
	end

	assign result.result_block = res_q;
	assign result.free_left    = 16'(cnt_q);
	assign result.status       = stat_q;

	a_ff_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ff_q != '0) && (32'(ff_q) < NUM_BLOCKS))
		else $error("first-free pointer out of range");

	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= BLK_LAST)
		else $error("free count above table size");

	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (state_q != S_IDLE))
		else $error("transfer accepted without starting work");

	a_rd_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_WAIT) |-> !mreq.we)
		else $error("table write during read command");

	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("two results for one command");

endmodule

`default_nettype wire

[rtl/block_chain_allocator_top.sv]
// Commands: free walks the chain and releases each block (none for root or out of
//   range); allocate scans for a free block, then scans on for the next free block.
// Throughput: one command at a time; scans and chain walks run one table read
//   per cycle on a single synchronous table RAM.
// Reset: async active low; after release a clearing pass initializes the table
//   (root = end of chain) and no command is taken meanwhile.
`default_nettype none

module block_chain_allocator_top
	import bca_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	bca_in_if.sink    cmd_ch,
	bca_out_if.source rsp_ch
);

	mem_req_t     mreq;
	logic [15:0]  rdata;
	result_t      result;
	logic         done;
	logic         out_free;
	logic         ov_q;
	result_t      out_q;

	assign out_free = !ov_q || rsp_ch.ready;

	bca_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (cmd_ch.valid),
		.in_ready    (cmd_ch.ready),
		.cmd         (cmd_ch.cmd),
		.block_index (cmd_ch.block_index),
		.next_value  (cmd_ch.next_value),
		.out_free    (out_free),
		.done        (done),
		.result      (result),
		.mreq        (mreq),
		.rdata       (rdata)
	);

	bca_ram #(
		.DEPTH (NUM_BLOCKS),
		.WIDTH (16),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.rdata (rdata)
	);

	// output register; holds a result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (done) begin
			ov_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= result;
		end
	end

	assign rsp_ch.valid        = ov_q;
	assign rsp_ch.result_block = out_q.result_block;
	assign rsp_ch.free_left    = out_q.free_left;
	assign rsp_ch.status       = out_q.status;

endmodule

`default_nettype wire
